// ===== rtl/duplicate_free_set_table_defines.svh =====
// Assertion macros for the duplicate-free set table.
`ifndef DUPLICATE_FREE_SET_TABLE_DEFINES_SVH
`define DUPLICATE_FREE_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define DFST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfst: implication check failed");

// Next-cycle implication, checked outside reset
`define DFST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfst: next-cycle check failed");

`else

`define DFST_ASSERT_IMP(lbl, ante, cons)
`define DFST_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/dfst_pkg.sv =====
// Package: sizes, operation codes, states and transaction types of the set table.
package dfst_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned REQ_VAL_W   = 32;
  localparam int unsigned RSP_CNT_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 3'd0,
    MODE_REMOVE   = 3'd1,
    MODE_CONTAINS = 3'd2,
    MODE_COUNT    = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [REQ_VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 success;
    logic [RSP_CNT_W-1:0] match_count;
    logic [RSP_CNT_W-1:0] size;
  } rsp_t;

endpackage

// ===== rtl/duplicate_free_set_table.sv =====
// Duplicate-free set table: top level with scan sequencer and entry RAM.
// A request taken in idle is scanned over the filled entries, one entry per cycle,
// through the registered RAM read port; a drain state completes the last compare and
// the finish state writes the RAM and registers the response, waiting while it is stalled.
// Clear, unused modes and an empty set skip the scan; no new request is taken until idle.
// Reset: synchronous rst empties the set and drops any pending response; entries stay undefined.
`include "duplicate_free_set_table_defines.svh"

module duplicate_free_set_table
  import dfst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t                 state, state_next;
  logic [IDX_W-1:0]       cnt, cnt_next;
  logic                   cmp_vld;
  logic [IDX_W-1:0]       cmp_idx;
  logic [MODE_W-1:0]      mode_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [CNT_W-1:0]       hit_count;
  logic [VALUE_WIDTH-1:0] last_data;
  logic [CNT_W-1:0]       fill, fill_next;
  logic [IDX_W-1:0]       last_idx;

  logic                   req_take;
  logic                   slot_free;
  logic                   scan_needed;
  logic                   rd_en;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  rsp_t                   res;

  assign req_stall   = (state != ST_IDLE);
  assign req_take    = req_valid && !req_stall;
  assign slot_free   = !rsp_valid || !rsp_stall;
  assign last_idx    = IDX_W'(fill - CNT_W'(1));
  assign scan_needed = (fill != '0) &&
                       (req.mode inside {MODE_ADD, MODE_REMOVE, MODE_CONTAINS, MODE_COUNT});
  assign rd_en       = (state == ST_SCAN);

  dfst_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  // Sequencer next state, RAM write and result
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    fill_next  = fill;
    wr_en      = 1'b0;
    wr_addr    = hit_idx;
    wr_data    = last_data;
    res        = '0;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          cnt_next   = '0;
          state_next = scan_needed ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + IDX_W'(1);
        if (cnt == last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
          case (mode_r)
            MODE_ADD: begin
              if ((fill < CNT_W'(CAPACITY)) && !found) begin
                wr_en       = 1'b1;
                wr_addr     = IDX_W'(fill);
                wr_data     = value_r;
                fill_next   = fill + CNT_W'(1);
                res.success = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (found) begin
                // last entry fills the hole
                wr_en       = 1'b1;
                fill_next   = fill - CNT_W'(1);
                res.success = 1'b1;
              end
            end
            MODE_CONTAINS: begin
              res.success = found;
            end
            MODE_COUNT: begin
              res.success     = (hit_count != '0);
              res.match_count = RSP_CNT_W'(hit_count);
            end
            MODE_CLEAR: begin
              fill_next   = '0;
              res.success = 1'b1;
            end
            default: begin
            end
          endcase
          res.size = RSP_CNT_W'(fill_next);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmp_vld   <= 1'b0;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == ST_SCAN);
      if (state == ST_FINISH && slot_free) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture and match tracking
  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    cmp_idx <= cnt;
    if (state == ST_FINISH && slot_free) begin
      rsp <= res;
    end
    if (req_take) begin
      mode_r    <= req.mode;
      value_r   <= req.value[VALUE_WIDTH-1:0];
      found     <= 1'b0;
      hit_count <= '0;
    end else if (cmp_vld) begin
      if (rd_data == value_r) begin
        hit_count <= hit_count + CNT_W'(1);
        if (!found) begin
          found   <= 1'b1;
          hit_idx <= cmp_idx;
        end
      end
      if (cmp_idx == last_idx) begin
        last_data <= rd_data;
      end
    end
  end

  // Checks
  `DFST_ASSERT_IMP(a_fill_bound, 1'b1, fill <= CNT_W'(CAPACITY))
  `DFST_ASSERT_NXT(a_busy_after_take, req_take, state != ST_IDLE)
  `DFST_ASSERT_IMP(a_write_in_finish, wr_en, state == ST_FINISH && slot_free)
  `DFST_ASSERT_NXT(a_rsp_loaded, state == ST_FINISH && slot_free, rsp_valid)
  `DFST_ASSERT_IMP(a_scan_nonempty, state == ST_SCAN, fill != '0)

endmodule

// ===== rtl/dfst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
